[design/nfa_lms_pkg.sv]
// Shared types and constants for the NFA longest-match scanner.
`timescale 1ns / 1ps

package nfa_lms_pkg;

  // Fixed field widths of the item and result formats
  localparam int ST_MAX      = 64;   // widest state set
  localparam int SYM_W       = 8;
  localparam int ST_IDX_W    = 6;
  localparam int LEN_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // Defaults for the top-level parameters
  localparam int NUM_STATES_DEF    = 64;
  localparam int NUM_SYMBOLS_DEF   = 256;
  localparam int MAX_TOKEN_LEN_DEF = 255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL = 2'd1;

  // Command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [SYM_W-1:0]    symbol;
    logic [ST_IDX_W-1:0] src_state;
    logic [ST_IDX_W-1:0] dst_state;
  } item_t;

  typedef struct packed {
    logic              dead;
    logic              accepting;
    logic [LEN_W-1:0]  token_length;
    logic [LEN_W-1:0]  match_length;
    logic [ST_MAX-1:0] active_states;
  } result_t;

endpackage

[design/nfa_longest_match_scanner.sv]
// NFA longest-match scanner: transition memory, step sequencer and status output.
`timescale 1ns / 1ps

// Table-driven NFA scanner. Transitions live in one single-port synchronous
// memory with a row of destination bits per (source state, symbol) pair.
// After reset the block sweeps the memory to zero, one row per cycle, over
// all 2**(clog2(NUM_STATES) + clog2(NUM_SYMBOLS)) rows (16384 by default);
// in_ready_o stays low meanwhile, configuration writes are taken as usual.
// One item is worked on at a time and each item yields one status result.
// A transition load is a read-modify-write of one row: the row is read as
// the item is taken and written back in S_LOAD_WR. A step reads the rows of
// all NUM_STATES states through the single memory port, one per cycle, in
// S_STEP and folds in the last row in S_STEP_LAST; a begin, a step while
// dead or an unused command goes straight to S_DONE. The output register
// lets the next item be accepted while a result still waits for out_ready_i.
module nfa_longest_match_scanner
  import nfa_lms_pkg::*;
#(
  parameter int NUM_STATES    = NUM_STATES_DEF,
  parameter int NUM_SYMBOLS   = NUM_SYMBOLS_DEF,
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  item_t                 in_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               out_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SW        = $clog2(NUM_STATES);
  localparam int YW        = $clog2(NUM_SYMBOLS);
  localparam int AW        = SW + YW;
  localparam int DEPTH     = 1 << AW;
  localparam int COUNT_CAP = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;

  typedef enum logic [5:0] {
    S_CLEAR     = 6'b000001,
    S_IDLE      = 6'b000010,
    S_LOAD_WR   = 6'b000100,
    S_STEP      = 6'b001000,
    S_STEP_LAST = 6'b010000,
    S_DONE      = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [NUM_STATES-1:0] start_q, final_q;
  logic [NUM_STATES-1:0] active_q, active_d;
  logic [NUM_STATES-1:0] acc_q, acc_d;
  logic [LEN_W-1:0]      cnt_q, cnt_d;
  logic [LEN_W-1:0]      match_q, match_d;
  logic [AW-1:0]         clr_addr_q, clr_addr_d;
  logic [SW-1:0]         idx_q, idx_d;
  logic                  pend_q, pend_d;
  item_t                 item_q;
  logic                  out_valid_q;
  result_t               out_q;

  // memory port
  logic [NUM_STATES-1:0] mem [DEPTH];
  logic [NUM_STATES-1:0] rdata_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [NUM_STATES-1:0] mem_wdata;

  logic                  in_xfer;
  logic                  load_ok;
  logic                  sym_ok;
  logic                  out_free;
  logic [LEN_W-1:0]      cnt_inc;
  logic [NUM_STATES-1:0] step_set;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign load_ok  = (32'(in_i.symbol) < NUM_SYMBOLS) && (32'(in_i.src_state) < NUM_STATES)
                 && (32'(in_i.dst_state) < NUM_STATES);
  assign sym_ok   = 32'(in_i.symbol) < NUM_SYMBOLS;
  assign cnt_inc  = (cnt_q < LEN_W'(COUNT_CAP)) ? cnt_q + LEN_W'(1) : cnt_q;
  assign step_set = acc_q | (pend_q ? rdata_q : '0);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      final_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_START) start_q <= cfg_data_i[NUM_STATES-1:0];
      if (cfg_idx_i == CFG_FINAL) final_q <= cfg_data_i[NUM_STATES-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    match_d    = match_q;
    clr_addr_d = clr_addr_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = clr_addr_q;
    mem_wdata  = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + AW'(1);
        if (&clr_addr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DONE;
          unique case (in_i.cmd)
            CMD_LOAD: begin
              if (load_ok) begin
                mem_re   = 1'b1;
                mem_addr = {in_i.src_state[SW-1:0], in_i.symbol[YW-1:0]};
                state_d  = S_LOAD_WR;
              end
            end
            CMD_BEGIN: begin
              active_d = start_q;
              cnt_d    = '0;
              match_d  = '0;
            end
            CMD_STEP: begin
              if (active_q != '0) begin
                if (sym_ok) begin
                  acc_d   = '0;
                  idx_d   = '0;
                  state_d = S_STEP;
                end else begin
                  // no transitions for this symbol: set empties, count advances
                  active_d = '0;
                  cnt_d    = cnt_inc;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = {item_q.src_state[SW-1:0], item_q.symbol[YW-1:0]};
        mem_wdata = rdata_q | (NUM_STATES'(1) << item_q.dst_state);
        state_d   = S_DONE;
      end
      S_STEP: begin
        // read row of state idx; fold in the row read last cycle
        mem_re   = 1'b1;
        mem_addr = {idx_q, item_q.symbol[YW-1:0]};
        pend_d   = active_q[idx_q];
        acc_d    = step_set;
        idx_d    = idx_q + SW'(1);
        if (32'(idx_q) == NUM_STATES - 1) state_d = S_STEP_LAST;
      end
      S_STEP_LAST: begin
        active_d = step_set;
        cnt_d    = cnt_inc;
        if ((step_set & final_q) != '0) match_d = cnt_inc;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      active_q   <= '0;
      cnt_q      <= '0;
      match_q    <= '0;
      clr_addr_q <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      cnt_q      <= cnt_d;
      match_q    <= match_d;
      clr_addr_q <= clr_addr_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
    end
  end

  // datapath holding registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_xfer) item_q <= in_i;
  end

  // transition memory, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_q.dead          <= (active_q == '0);
      out_q.accepting     <= ((active_q & final_q) != '0);
      out_q.token_length  <= cnt_q;
      out_q.match_length  <= match_q;
      out_q.active_states <= ST_MAX'(active_q);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  a_step_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP || state_q == S_STEP_LAST) |-> !mem_we)
    else $error("memory write during a step");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("item accepted while another is in work");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LEN_W'(COUNT_CAP) && match_q <= cnt_q)
    else $error("counter beyond cap or match beyond count");

  a_dead_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.dead == (out_o.active_states == '0)))
    else $error("dead flag disagrees with active set");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!out_valid_q && !in_ready_o))
    else $error("activity during clearing pass");

endmodule

[test/testbench.sv]
// Self-checking testbench for the NFA longest-match scanner.
`timescale 1ns / 1ps

module testbench;
  import nfa_lms_pkg::*;

  // Register indexes past the end of the list: writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int RANDOM_ITEMS = 900;
  localparam int SAT_STEPS    = 300;
  localparam int HOLD_CYCLES  = 400;
  // Limit must exceed the clearing sweep of all 16384 rows and a step with stalls
  localparam int IDLE_LIMIT   = 60000;
  localparam int TAIL_CYCLES  = 80;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  item_t                 in_item  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  result_t               out_status;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nfa_longest_match_scanner u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_status),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Scanner shadow state
  bit [ST_MAX-1:0] scan_start;
  bit [ST_MAX-1:0] scan_final;
  bit [ST_MAX-1:0] scan_active;
  bit [ST_MAX-1:0] trans_rows [0:(1 << (ST_IDX_W + SYM_W)) - 1];
  bit [LEN_W-1:0]  tok_count;
  bit [LEN_W-1:0]  best_match;

  item_t   pending_items[$];
  result_t expected_status[$];

  int items_queued   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int steps_accepted = 0;
  int loads_accepted = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  int in_wait        = 0;
  int in_calm        = 0;
  int out_wait       = 0;
  int out_calm       = 0;
  bit in_taken       = 1'b0;
  bit out_taken      = 1'b0;
  bit stall_hold     = 1'b0;

  // Apply one item to the shadow state and return the status it reports
  function automatic result_t scan_predict(item_t it);
    bit [ST_MAX-1:0] nxt;
    result_t         res;
    case (it.cmd)
      CMD_LOAD: trans_rows[{it.src_state, it.symbol}][it.dst_state] = 1'b1;
      CMD_BEGIN: begin
        scan_active = scan_start;
        tok_count   = '0;
        best_match  = '0;
      end
      CMD_STEP: begin
        // a dead scanner ignores the symbol and keeps its count
        if (scan_active != '0) begin
          nxt = '0;
          for (int s = 0; s < ST_MAX; s++)
            if (scan_active[s]) nxt |= trans_rows[{6'(s), it.symbol}];
          scan_active = nxt;
          if (tok_count != '1) tok_count++;
          if ((scan_active & scan_final) != '0) best_match = tok_count;
        end
      end
      default: ;
    endcase
    res.dead          = (scan_active == '0);
    res.accepting     = ((scan_active & scan_final) != '0);
    res.token_length  = tok_count;
    res.match_length  = best_match;
    res.active_states = scan_active;
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_item(cmd_e c, bit [SYM_W-1:0] sym, bit [ST_IDX_W-1:0] src,
                                     bit [ST_IDX_W-1:0] dst);
    item_t it;
    it.cmd       = c;
    it.symbol    = sym;
    it.src_state = src;
    it.dst_state = dst;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_step(bit [SYM_W-1:0] sym);
    queue_item(CMD_STEP, sym, 6'($urandom), 6'($urandom));
  endfunction

  function automatic void queue_begin();
    queue_item(CMD_BEGIN, 8'($urandom), 6'($urandom), 6'($urandom));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_START) scan_start = data;
    else if (idx == CFG_FINAL) scan_final = data;
  endtask

  // Block is idle once every queued item has produced its status
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Sender: record the transfer and predict its status
  always @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      expected_status.push_back(scan_predict(in_item));
      void'(pending_items.pop_front());
      items_accepted++;
      if (in_item.cmd == CMD_STEP) steps_accepted++;
      if (in_item.cmd == CMD_LOAD) loads_accepted++;
      in_taken = 1'b1;
    end
  end

  // Sender: present the next item after a random gap
  always @(negedge clk_i) begin
    bit fresh;
    fresh = in_taken || !in_valid;
    if (in_taken) begin
      in_taken = 1'b0;
      in_wait  = pick_gap(in_calm);
    end
    if (rst_n && fresh) begin
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_item  <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each status transfer against the oldest prediction
  always @(posedge clk_i) begin
    result_t exp_st;
    if (out_valid && out_ready) begin
      results_seen++;
      out_taken = 1'b1;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: status %0d arrived with nothing outstanding: %p", results_seen,
                   out_status);
      end else begin
        exp_st = expected_status.pop_front();
        if (out_status.dead !== exp_st.dead || out_status.accepting !== exp_st.accepting ||
            out_status.token_length !== exp_st.token_length ||
            out_status.match_length !== exp_st.match_length ||
            out_status.active_states !== exp_st.active_states) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: status %0d expected dead=%0b acc=%0b tok=%0d match=%0d act=%h",
                     results_seen, exp_st.dead, exp_st.accepting, exp_st.token_length,
                     exp_st.match_length, exp_st.active_states);
            $display("tb: status %0d got      dead=%0b acc=%0b tok=%0d match=%0d act=%h",
                     results_seen, out_status.dead, out_status.accepting,
                     out_status.token_length, out_status.match_length,
                     out_status.active_states);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off
  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait  = pick_gap(out_calm);
    end
    if (stall_hold || !rst_n) begin
      out_ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long receiver hold-off while the sender still has plenty queued
  initial begin
    while (!(results_seen >= 150 && pending_items.size() > 20)) @(posedge clk_i);
    stall_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    stall_hold = 1'b0;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus
  initial begin
    bit [ST_MAX-1:0]   start_val;
    bit [ST_MAX-1:0]   final_val;
    bit [ST_MAX-1:0]   pool_mask;
    bit [ST_IDX_W-1:0] pool [6];
    bit [SYM_W-1:0]    alpha [3];
    bit [ST_IDX_W-1:0] sat_state;
    bit [SYM_W-1:0]    sat_sym;
    int                random_base;
    int                len;
    int                r;

    repeat (4) @(negedge clk_i);
    rst_n = 1'b1;

    // Registers can be written during the clearing sweep
    write_reg(CFG_START, (64'd1 << 0) | (64'd1 << 63));
    write_reg(CFG_FINAL, 64'd1 << 63);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, {$urandom, $urandom});

    // Directed: edge states and symbols, dead steps, unused command
    queue_item(CMD_LOAD, 8'd0, 6'd0, 6'd63);
    queue_item(CMD_LOAD, 8'd255, 6'd63, 6'd0);
    queue_item(CMD_LOAD, 8'h5a, 6'd0, 6'd0);
    queue_item(CMD_LOAD, 8'h5a, 6'd0, 6'd0);
    queue_item(CMD_LOAD, 8'd0, 6'd63, 6'd63);
    queue_item(CMD_NOP, 8'hff, 6'h3f, 6'h3f);
    queue_step(8'd0);           // before any begin: dead
    queue_begin();              // accepting at length zero, no match
    queue_step(8'd0);
    queue_step(8'd255);
    queue_step(8'h5a);
    queue_step(8'd0);
    queue_step(8'h11);          // no row: set empties, count advances
    queue_step(8'h11);          // dead: count holds
    queue_item(CMD_NOP, 8'd0, 6'd0, 6'd0);
    queue_begin();
    queue_step(8'd255);
    queue_item(CMD_LOAD, 8'd0, 6'd0, 6'd0);
    queue_step(8'd0);
    queue_item(CMD_BEGIN, 8'hff, 6'h3f, 6'h3f);
    queue_step(8'h5a);

    // Saturate the count on a self loop, then make it accept
    wait_drained();
    sat_state = 6'($urandom);
    sat_sym   = 8'($urandom);
    write_reg(CFG_START, 64'd1 << sat_state);
    write_reg(CFG_FINAL, '0);
    queue_item(CMD_LOAD, sat_sym, sat_state, sat_state);
    queue_begin();
    for (int j = 0; j < SAT_STEPS; j++) queue_step(sat_sym);
    wait_drained();
    write_reg(CFG_FINAL, 64'd1 << sat_state);
    queue_step(sat_sym);
    wait_drained();
    write_reg(CFG_FINAL, '0);   // recorded match survives
    queue_step(sat_sym);

    // Random phases: small NFA per phase, then tokens over its alphabet
    random_base = items_queued;
    for (int ph = 0; items_queued - random_base < RANDOM_ITEMS; ph++) begin
      wait_drained();
      pool_mask = '0;
      for (int k = 0; k < 6; k++) begin
        pool[k] = 6'($urandom);
        pool_mask[pool[k]] = 1'b1;
      end
      for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom);
      if (ph == 0) begin
        alpha[0] = 8'd0;
        alpha[1] = 8'd255;
      end
      case (ph % 6)
        0: begin
          start_val = (pool_mask & {$urandom, $urandom}) | (64'd1 << pool[0]);
          final_val = pool_mask & {$urandom, $urandom};
        end
        1: begin
          start_val = '1;
          final_val = {$urandom, $urandom};
        end
        2: begin
          start_val = 64'd1 << pool[0];
          final_val = '1;
        end
        3: begin
          start_val = (pool_mask & {$urandom, $urandom}) | (64'd1 << pool[1]);
          final_val = '0;
        end
        4: begin
          start_val = '0;
          final_val = pool_mask;
        end
        default: begin
          start_val = {$urandom, $urandom};
          final_val = {$urandom, $urandom};
        end
      endcase
      write_reg(CFG_START, start_val);
      write_reg(CFG_FINAL, final_val);

      for (int k = 0; k < 24; k++)
        queue_item(CMD_LOAD, alpha[$urandom_range(0, 2)], pool[$urandom_range(0, 5)],
                   pool[$urandom_range(0, 5)]);
      for (int k = 0; k < 2; k++)
        queue_item(CMD_LOAD, 8'($urandom), 6'($urandom), 6'($urandom));

      for (int t = 0; t < 8; t++) begin
        queue_begin();
        len = $urandom_range(1, 16);
        for (int j = 0; j < len; j++) begin
          r = $urandom_range(0, 99);
          if (r < 5) queue_item(CMD_NOP, 8'($urandom), 6'($urandom), 6'($urandom));
          else if (r < 8) queue_item(CMD_LOAD, 8'($urandom), 6'($urandom), 6'($urandom));
          else if (r < 10) queue_begin();
          else if (r < 88) queue_step(alpha[$urandom_range(0, 2)]);
          else queue_step(8'($urandom));
        end
      end
    end

    // Drain, then give a late or extra status time to show up
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: %0d items transferred (%0d steps, %0d loads), %0d statuses checked",
             items_accepted, steps_accepted, loads_accepted, results_seen);
    $display("tb: count saturation, dead steps and a %0d-cycle output hold-off included",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
